/* design/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg
// Shared widths, prescaler codes and shift amounts for the tone timer
// prescaler select block.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int unsigned FREQ_W = 15;
	localparam int unsigned TOP_W  = 8;
	localparam int unsigned CS_W   = 3;

	localparam int unsigned NUM_PRESC = 6;

	localparam logic [CS_W-1:0] CS_DIV1    = 3'b001;
	localparam logic [CS_W-1:0] CS_DIV8    = 3'b010;
	localparam logic [CS_W-1:0] CS_DIV32   = 3'b011;
	localparam logic [CS_W-1:0] CS_DIV128  = 3'b101;
	localparam logic [CS_W-1:0] CS_DIV256  = 3'b110;
	localparam logic [CS_W-1:0] CS_DIV1024 = 3'b111;

	localparam logic [TOP_W-1:0] TOP_MAX = 8'd255;

	localparam logic [CS_W-1:0] PRESC_CODE [NUM_PRESC] = '{
		CS_DIV1, CS_DIV8, CS_DIV32, CS_DIV128, CS_DIV256, CS_DIV1024
	};

	localparam logic [3:0] PRESC_SHIFT [NUM_PRESC] = '{
		4'd0, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10
	};

endpackage

/* design/tone_timer_prescaler_select.sv */
// ----------------------------------------------------------------------------
// tone_timer_prescaler_select
// Turns a tone frequency into the compare top and clock-select code of an
// 8-bit waveform timer.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the freq channel (freq_valid/freq_ready, frequency_hz)
//   yields one result on the result channel (result_valid/result_ready,
//   compare_top, clock_select, out_of_range).
//   The quotient floor(CLOCK_HZ/2 / frequency_hz) is formed by a row of
//   restoring division cells, one quotient bit per cell, NW cells with
//   NW = bit width of CLOCK_HZ/2 (23 at 16 MHz). A select stage then picks
//   the prescaler and registers the result.
//   One request is taken per cycle unless a stalled receiver has backed up the row.
//   Each cell has its own valid bit and ready is passed back cell by cell,
//   so a stalled receiver only blocks intake once every stage is full;
//   bubbles are squeezed out while the receiver stalls.
//   Reset clears all valid bits; the row is empty and ready right after.
//   A frequency of zero or one too low for /1024 gives top 255, code 7
//   and out_of_range set.
// ----------------------------------------------------------------------------
module tone_timer_prescaler_select #(
	parameter int unsigned CLOCK_HZ = 16000000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          freq_valid,
	output logic                          freq_ready,
	input  logic [tts_pkg::FREQ_W-1:0]    frequency_hz,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [tts_pkg::TOP_W-1:0]     compare_top,
	output logic [tts_pkg::CS_W-1:0]      clock_select,
	output logic                          out_of_range
);

	localparam int unsigned      HALF_CLK = CLOCK_HZ / 2;
	localparam int unsigned      NW       = $clog2(HALF_CLK + 1);
	localparam logic [NW-1:0]    DIVIDEND = NW'(HALF_CLK);

	logic                         v    [NW+1];
	logic                         r    [NW+1];
	logic [tts_pkg::FREQ_W-1:0]   f    [NW+1];
	logic [tts_pkg::FREQ_W-1:0]   rem  [NW+1];
	logic [NW-1:0]                quo  [NW+1];

	assign v[0]       = freq_valid;
	assign freq_ready = r[0];
	assign f[0]       = frequency_hz;
	assign rem[0]     = '0;
	assign quo[0]     = '0;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		tts_div_cell #(
			.NW   (NW),
			.DBIT (DIVIDEND[NW-1-i])
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (v[i]),
			.up_ready (r[i]),
			.up_f     (f[i]),
			.up_rem   (rem[i]),
			.up_quo   (quo[i]),
			.dn_valid (v[i+1]),
			.dn_ready (r[i+1]),
			.dn_f     (f[i+1]),
			.dn_rem   (rem[i+1]),
			.dn_quo   (quo[i+1])
		);
	end

	tts_select #(
		.NW (NW)
	) u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (v[NW]),
		.up_ready     (r[NW]),
		.up_f         (f[NW]),
		.up_quo       (quo[NW]),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.compare_top  (compare_top),
		.clock_select (clock_select),
		.out_of_range (out_of_range)
	);

endmodule

/* design/tts_div_cell.sv */
// ----------------------------------------------------------------------------
// tts_div_cell
// One restoring division step: brings in a fixed dividend bit, trial
// subtracts the divisor and hands remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module tts_div_cell #(
	parameter int unsigned NW   = 23,
	parameter bit          DBIT = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic [tts_pkg::FREQ_W-1:0]    up_f,
	input  logic [tts_pkg::FREQ_W-1:0]    up_rem,
	input  logic [NW-1:0]                 up_quo,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic [tts_pkg::FREQ_W-1:0]    dn_f,
	output logic [tts_pkg::FREQ_W-1:0]    dn_rem,
	output logic [NW-1:0]                 dn_quo
);

	logic                         valid_q;
	logic [tts_pkg::FREQ_W-1:0]   f_q;
	logic [tts_pkg::FREQ_W-1:0]   rem_q;
	logic [NW-1:0]                quo_q;
	logic [tts_pkg::FREQ_W:0]     trial;
	logic [tts_pkg::FREQ_W:0]     diff;
	logic                         ge;
	logic [tts_pkg::FREQ_W-1:0]   rem_next;

	assign trial    = {up_rem, DBIT};
	assign diff     = trial - {1'b0, up_f};
	assign ge       = trial >= {1'b0, up_f};
	assign rem_next = ge ? diff[tts_pkg::FREQ_W-1:0] : trial[tts_pkg::FREQ_W-1:0];

	assign up_ready = ~valid_q | dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			f_q   <= up_f;
			rem_q <= rem_next;
			quo_q <= {up_quo[NW-2:0], ge};
		end
	end

	assign dn_valid = valid_q;
	assign dn_f     = f_q;
	assign dn_rem   = rem_q;
	assign dn_quo   = quo_q;

endmodule

/* design/tts_select.sv */
// ----------------------------------------------------------------------------
// tts_select
// Picks the first prescaler whose shifted quotient fits the 8-bit top and
// holds the finished result for the receiver.
// ----------------------------------------------------------------------------
module tts_select #(
	parameter int unsigned NW = 23
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic [tts_pkg::FREQ_W-1:0]    up_f,
	input  logic [NW-1:0]                 up_quo,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [tts_pkg::TOP_W-1:0]     compare_top,
	output logic [tts_pkg::CS_W-1:0]      clock_select,
	output logic                          out_of_range
);

	localparam logic [NW-1:0] TOP_LIMIT = NW'(256);

	logic                         valid_q;
	logic [tts_pkg::TOP_W-1:0]    top_q;
	logic [tts_pkg::CS_W-1:0]     cs_q;
	logic                         oor_q;
	logic [tts_pkg::TOP_W-1:0]    top_d;
	logic [tts_pkg::CS_W-1:0]     cs_d;
	logic                         oor_d;

	always_comb begin
		logic          found;
		logic [NW-1:0] t;
		logic [NW-1:0] t_m1;
		found = 1'b0;
		top_d = tts_pkg::TOP_MAX;
		cs_d  = tts_pkg::CS_DIV1024;
		oor_d = 1'b1;
		t     = '0;
		t_m1  = '0;
		if (up_f == '0) begin
			found = 1'b1;
		end else if (up_quo == '0) begin
			top_d = '0;
			cs_d  = tts_pkg::CS_DIV1;
			oor_d = 1'b1;
		end else begin
			for (int k = 0; k < tts_pkg::NUM_PRESC; k++) begin
				t    = up_quo >> tts_pkg::PRESC_SHIFT[k];
				t_m1 = t - NW'(1);
				if (!found && t <= TOP_LIMIT) begin
					found = 1'b1;
					top_d = (t == '0) ? '0 : t_m1[tts_pkg::TOP_W-1:0];
					cs_d  = tts_pkg::PRESC_CODE[k];
					oor_d = 1'b0;
				end
			end
		end
	end

	assign up_ready = ~valid_q | result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			top_q <= top_d;
			cs_q  <= cs_d;
			oor_q <= oor_d;
		end
	end

	assign result_valid = valid_q;
	assign compare_top  = top_q;
	assign clock_select = cs_q;
	assign out_of_range = oor_q;

endmodule

/* test/tone_timer_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_timer_result_checker
// Watches the request and result channels of the tone timer prescaler select
// block. Every accepted frequency gets a predicted compare top, clock-select
// code and range flag. Every accepted result is checked against the oldest
// prediction. The mismatch count and the number of pending predictions are
// passed back to the testbench top.
// ----------------------------------------------------------------------------
module tone_timer_result_checker #(
	parameter int unsigned CLOCK_HZ = 16000000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          freq_valid,
	input  logic                          freq_ready,
	input  logic [tts_pkg::FREQ_W-1:0]    frequency_hz,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic [tts_pkg::TOP_W-1:0]     compare_top,
	input  logic [tts_pkg::CS_W-1:0]      clock_select,
	input  logic                          out_of_range,
	output int                            fail_count,
	output int                            outstanding
);

	typedef struct packed {
		logic [tts_pkg::TOP_W-1:0] top;
		logic [tts_pkg::CS_W-1:0]  cs;
		logic                      oor;
	} timer_setting_t;

	timer_setting_t expected_settings [$];
	int mismatches = 0;

	function automatic timer_setting_t select_prescaler(
		input logic [tts_pkg::FREQ_W-1:0] freq
	);
		timer_setting_t setting;
		int unsigned half_period;
		int unsigned scaled;
		int unsigned scaled_m1;
		bit found;
		setting.top = tts_pkg::TOP_MAX;
		setting.cs  = tts_pkg::CS_DIV1024;
		setting.oor = 1'b1;
		found = 1'b0;
		if (freq != '0) begin
			half_period = CLOCK_HZ / (32'd2 * freq);
			if (half_period == 0) begin
				setting.top = '0;
				setting.cs  = tts_pkg::CS_DIV1;
				setting.oor = 1'b1;
			end else begin
				for (int i = 0; i < tts_pkg::NUM_PRESC; i++) begin
					scaled    = half_period >> tts_pkg::PRESC_SHIFT[i];
					scaled_m1 = scaled - 1;
					if (!found && (scaled == 0 || scaled_m1 <= tts_pkg::TOP_MAX)) begin
						setting.top = (scaled == 0) ? '0 : scaled_m1[tts_pkg::TOP_W-1:0];
						setting.cs  = tts_pkg::PRESC_CODE[i];
						setting.oor = 1'b0;
						found = 1'b1;
					end
				end
			end
		end
		return setting;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		timer_setting_t want;
		if (!arst_n) begin
			expected_settings.delete();
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_settings.size() == 0) begin
					$error("unexpected result: compare_top %0d, clock_select %0d, out_of_range %0d",
						compare_top, clock_select, out_of_range);
					mismatches++;
				end else begin
					want = expected_settings.pop_front();
					if (compare_top !== want.top) begin
						$error("compare_top: expected %0d, got %0d", want.top, compare_top);
						mismatches++;
					end
					if (clock_select !== want.cs) begin
						$error("clock_select: expected %0d, got %0d", want.cs, clock_select);
						mismatches++;
					end
					if (out_of_range !== want.oor) begin
						$error("out_of_range: expected %0d, got %0d", want.oor, out_of_range);
						mismatches++;
					end
				end
			end
			if (freq_valid && freq_ready)
				expected_settings.push_back(select_prescaler(frequency_hz));
			outstanding <= expected_settings.size();
			fail_count <= mismatches;
		end
	end

endmodule

/* test/tb_tone_timer_prescaler_select.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tone_timer_prescaler_select
// Drives tone frequencies into the prescaler select block: first the corner
// values around each prescaler boundary and the range limits, then random
// frequencies spread over all magnitudes. Both sides idle at random, with
// stretches at full rate. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_tone_timer_prescaler_select;

	localparam int unsigned CLOCK_HZ = 16000000;
	localparam int RANDOM_REQUESTS = 950;
	localparam int DRAIN_CYCLES = 2 * ($clog2(CLOCK_HZ / 2 + 1) + 1);
	localparam int STALL_LIMIT = 1000;

	localparam logic [tts_pkg::FREQ_W-1:0] CORNER_FREQS [24] = '{
		15'd0, 15'd1, 15'd2, 15'd30, 15'd31, 15'd32,
		15'd121, 15'd122, 15'd123, 15'd243, 15'd244, 15'd245,
		15'd972, 15'd973, 15'd974, 15'd3891, 15'd3892, 15'd10922,
		15'd16384, 15'd21845, 15'd31249, 15'd31250, 15'd31251, 15'd32767
	};

	logic                         clk;
	logic                         arst_n;
	logic                         freq_valid;
	logic                         freq_ready;
	logic [tts_pkg::FREQ_W-1:0]   frequency_hz;
	logic                         result_valid;
	logic                         result_ready;
	logic [tts_pkg::TOP_W-1:0]    compare_top;
	logic [tts_pkg::CS_W-1:0]     clock_select;
	logic                         out_of_range;
	logic                         steady;
	int                           fail_count;
	int                           outstanding;
	int                           idle_cycles = 0;

	tone_timer_prescaler_select #(
		.CLOCK_HZ(CLOCK_HZ)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.freq_valid(freq_valid),
		.freq_ready(freq_ready),
		.frequency_hz(frequency_hz),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.compare_top(compare_top),
		.clock_select(clock_select),
		.out_of_range(out_of_range)
	);

	tone_timer_result_checker #(
		.CLOCK_HZ(CLOCK_HZ)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.freq_valid(freq_valid),
		.freq_ready(freq_ready),
		.frequency_hz(frequency_hz),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.compare_top(compare_top),
		.clock_select(clock_select),
		.out_of_range(out_of_range),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((freq_valid && freq_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [tts_pkg::FREQ_W-1:0] random_frequency();
		int unsigned width;
		int unsigned value;
		width = $urandom_range(1, tts_pkg::FREQ_W);
		value = $urandom_range(0, (32'd1 << width) - 1);
		return value[tts_pkg::FREQ_W-1:0];
	endfunction

	task automatic send_frequency(input logic [tts_pkg::FREQ_W-1:0] freq);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			freq_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		freq_valid <= 1'b1;
		frequency_hz <= freq;
		do @(posedge clk); while (!freq_ready);
	endtask

	// hold new requests until every pending result is back
	task automatic drain_results();
		freq_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin : result_sink
		int unsigned stall;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		arst_n <= 1'b0;
		freq_valid <= 1'b0;
		frequency_hz <= '0;
		steady <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (CORNER_FREQS[i])
			send_frequency(CORNER_FREQS[i]);
		drain_results();
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 64 == 0)
				steady <= ($urandom_range(0, 3) == 0);
			if (n == RANDOM_REQUESTS / 2)
				drain_results();
			send_frequency(random_frequency());
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
